[src/ppcd_pkg.sv]
// ----------------------------------------------------------------------------
// ppcd_pkg
// Shared types and constants of the path pair conflict detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ppcd_pkg;

  // Width of an agent identifier.
  localparam int unsigned AgentBits = 8;

  // Kind of conflict reported with a result.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_EDGE   = 2'd2
  } ppcd_kind_e;

endpackage : ppcd_pkg

`default_nettype wire

[src/path_pair_conflict_detector.sv]
// ----------------------------------------------------------------------------
// path_pair_conflict_detector
// First vertex or edge-swap conflict between two streamed agent paths.
// ----------------------------------------------------------------------------
// Path: each timestep request waits in the input register; the last one is
//   checked into the result register once that register has room.
// Throughput: one timestep request per cycle unless the last one is waiting
//   for room; the check is a handful of cell compares against the registered
//   previous cells and is combinational.
// Reset: rst_ni clears both registers' valid flags and all per-pair state;
//   the block takes requests from the first cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module path_pair_conflict_detector #(
  parameter int unsigned COORD_BITS = 8,
  parameter int unsigned STEP_BITS  = 10,
  localparam int unsigned InBits    = 2 * 8 + 2 + 4 * COORD_BITS,
  localparam int unsigned InWidth   = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits   = 2 * 8 + 4 * COORD_BITS + STEP_BITS,
  localparam int unsigned OutWidth  = ((OutBits + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Timestep requests.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata, lowest bit up: agent_first, agent_second, first_valid, first_row,
  // first_col, second_valid, second_row, second_col, zero fill
  input  wire logic [InWidth-1:0]  s_axis_tdata,
  // tlast: last_step
  input  wire logic                s_axis_tlast,
  // Results.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata, lowest bit up: agent_first_out, agent_second_out, cell_row,
  // cell_col, prior_row, prior_col, conflict_time, zero fill
  output logic [OutWidth-1:0]      m_axis_tdata,
  // tuser: conflict_kind
  output logic [1:0]               m_axis_tuser
);
  import ppcd_pkg::*;

  // Field offsets within the request word.
  localparam int unsigned OffAgentA = 0;
  localparam int unsigned OffAgentB = OffAgentA + AgentBits;
  localparam int unsigned OffFValid = OffAgentB + AgentBits;
  localparam int unsigned OffFRow   = OffFValid + 1;
  localparam int unsigned OffFCol   = OffFRow + COORD_BITS;
  localparam int unsigned OffSValid = OffFCol + COORD_BITS;
  localparam int unsigned OffSRow   = OffSValid + 1;
  localparam int unsigned OffSCol   = OffSRow + COORD_BITS;

  logic               item_valid;
  logic [InWidth-1:0] item_data;
  logic               item_last;
  logic               out_free;
  logic               advance;

  ppcd_kind_e            res_kind;
  logic [COORD_BITS-1:0] res_row, res_col, res_prow, res_pcol;
  logic [STEP_BITS-1:0]  res_time;
  logic [OutWidth-1:0]   res_data;
  ppcd_kind_e            out_kind;

  // A timestep with no result moves on at once; the last one waits for room
  // in the result register.
  assign advance = item_valid && (!item_last || out_free);

  ppcd_in_reg #(
    .DataBits (InWidth)
  ) u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .take_i    (advance),
    .valid_o   (item_valid),
    .data_o    (item_data),
    .last_o    (item_last)
  );

  ppcd_core #(
    .CoordBits (COORD_BITS),
    .StepBits  (STEP_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .last_i         (item_last),
    .first_valid_i  (item_data[OffFValid]),
    .first_row_i    (item_data[OffFRow +: COORD_BITS]),
    .first_col_i    (item_data[OffFCol +: COORD_BITS]),
    .second_valid_i (item_data[OffSValid]),
    .second_row_i   (item_data[OffSRow +: COORD_BITS]),
    .second_col_i   (item_data[OffSCol +: COORD_BITS]),
    .res_kind_o     (res_kind),
    .res_row_o      (res_row),
    .res_col_o      (res_col),
    .res_prow_o     (res_prow),
    .res_pcol_o     (res_pcol),
    .res_time_o     (res_time)
  );

  // Pack the result; agent ids come from the last timestep request.
  assign res_data = OutWidth'({res_time, res_pcol, res_prow, res_col, res_row,
                               item_data[OffAgentB +: AgentBits],
                               item_data[OffAgentA +: AgentBits]});

  ppcd_out_reg #(
    .DataBits (OutWidth)
  ) u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance && item_last),
    .kind_i    (res_kind),
    .data_i    (res_data),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_kind_o  (out_kind),
    .m_data_o  (m_axis_tdata)
  );

  assign m_axis_tuser = out_kind;

endmodule : path_pair_conflict_detector

`default_nettype wire

[src/ppcd_in_reg.sv]
// ----------------------------------------------------------------------------
// ppcd_in_reg
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcd_in_reg #(
  parameter int unsigned DataBits = 56
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire logic [DataBits-1:0] s_data_i,
  input  wire logic                s_last_i,
  input  wire logic                take_i,
  output logic                     valid_o,
  output logic [DataBits-1:0]      data_o,
  output logic                     last_o
);

  logic                valid_q, valid_d;
  logic [DataBits-1:0] data_q;
  logic                last_q;
  logic                load;

  // Accept a new request when empty or when the held one leaves this cycle.
  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_data_i;
      last_q <= s_last_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule : ppcd_in_reg

`default_nettype wire

[src/ppcd_core.sv]
// ----------------------------------------------------------------------------
// ppcd_core
// Per-pair state and the vertex / edge conflict checks for one timestep.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcd_core #(
  parameter int unsigned CoordBits = 8,
  parameter int unsigned StepBits  = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire logic                   last_i,
  input  wire logic                   first_valid_i,
  input  wire logic [CoordBits-1:0]   first_row_i,
  input  wire logic [CoordBits-1:0]   first_col_i,
  input  wire logic                   second_valid_i,
  input  wire logic [CoordBits-1:0]   second_row_i,
  input  wire logic [CoordBits-1:0]   second_col_i,
  output ppcd_pkg::ppcd_kind_e        res_kind_o,
  output logic [CoordBits-1:0]        res_row_o,
  output logic [CoordBits-1:0]        res_col_o,
  output logic [CoordBits-1:0]        res_prow_o,
  output logic [CoordBits-1:0]        res_pcol_o,
  output logic [StepBits-1:0]         res_time_o
);
  import ppcd_pkg::*;

  localparam int unsigned CellBits = 2 * CoordBits;
  localparam logic [StepBits-1:0] StepMax = {StepBits{1'b1}};

  logic [CellBits-1:0] prev_first_q, prev_first_d;
  logic [CellBits-1:0] prev_second_q, prev_second_d;
  logic [StepBits-1:0] step_q, step_d;
  logic                found_q, found_d;
  logic                empty_q, empty_d;
  logic                first_end_q, first_end_d;
  logic                second_end_q, second_end_d;
  ppcd_kind_e          rec_kind_q, rec_kind_d;
  logic [CellBits-1:0] rec_cell_q, rec_cell_d;
  logic [CellBits-1:0] rec_prior_q, rec_prior_d;
  logic [StepBits-1:0] rec_time_q, rec_time_d;

  logic [CellBits-1:0] fcell, scell;
  logic                fa, sa, empty_now, hit_now, report;

  assign fcell = {first_row_i, first_col_i};
  assign scell = {second_row_i, second_col_i};
  assign fa    = first_valid_i && !first_end_q;
  assign sa    = second_valid_i && !second_end_q;

  assign empty_now = empty_q || ((step_q == '0) && (!fa || !sa));

  // Conflict search for this timestep; a parked path sits on its last cell.
  always_comb begin
    hit_now     = 1'b0;
    rec_kind_d  = rec_kind_q;
    rec_cell_d  = rec_cell_q;
    rec_prior_d = rec_prior_q;
    rec_time_d  = rec_time_q;
    if (!found_q && !empty_now) begin
      priority if (fa && sa) begin
        if (fcell == scell) begin
          hit_now     = 1'b1;
          rec_kind_d  = KIND_VERTEX;
          rec_cell_d  = fcell;
          rec_prior_d = '0;
        end else if ((step_q != '0) && (fcell == prev_second_q)
                     && (prev_first_q == scell)) begin
          hit_now     = 1'b1;
          rec_kind_d  = KIND_EDGE;
          rec_cell_d  = fcell;
          rec_prior_d = prev_first_q;
        end
      end else if (fa) begin
        if (fcell == prev_second_q) begin
          hit_now     = 1'b1;
          rec_kind_d  = KIND_VERTEX;
          rec_cell_d  = fcell;
          rec_prior_d = '0;
        end
      end else if (sa) begin
        if (prev_first_q == scell) begin
          hit_now     = 1'b1;
          rec_kind_d  = KIND_VERTEX;
          rec_cell_d  = scell;
          rec_prior_d = '0;
        end
      end else begin
        hit_now = 1'b0;
      end
    end
    if (hit_now) begin
      rec_time_d = step_q;
    end
  end

  assign report = (found_q || hit_now) && !empty_now;

  // Result as it stands after this timestep.
  assign res_kind_o = report ? rec_kind_d : KIND_NONE;
  assign res_row_o  = report ? rec_cell_d[CellBits-1:CoordBits] : '0;
  assign res_col_o  = report ? rec_cell_d[CoordBits-1:0] : '0;
  assign res_prow_o = report ? rec_prior_d[CellBits-1:CoordBits] : '0;
  assign res_pcol_o = report ? rec_prior_d[CoordBits-1:0] : '0;
  assign res_time_o = report ? rec_time_d : '0;

  always_comb begin
    prev_first_d  = fa ? fcell : prev_first_q;
    prev_second_d = sa ? scell : prev_second_q;
    first_end_d   = first_end_q || !fa;
    second_end_d  = second_end_q || !sa;
    step_d        = (step_q != StepMax) ? step_q + 1'b1 : step_q;
    found_d       = found_q || hit_now;
    empty_d       = empty_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_first_q  <= '0;
      prev_second_q <= '0;
      step_q        <= '0;
      found_q       <= 1'b0;
      empty_q       <= 1'b0;
      first_end_q   <= 1'b0;
      second_end_q  <= 1'b0;
      rec_kind_q    <= KIND_NONE;
      rec_cell_q    <= '0;
      rec_prior_q   <= '0;
      rec_time_q    <= '0;
    end else if (advance_i) begin
      if (last_i) begin
        // End of pair: drop everything back to the reset value.
        prev_first_q  <= '0;
        prev_second_q <= '0;
        step_q        <= '0;
        found_q       <= 1'b0;
        empty_q       <= 1'b0;
        first_end_q   <= 1'b0;
        second_end_q  <= 1'b0;
        rec_kind_q    <= KIND_NONE;
        rec_cell_q    <= '0;
        rec_prior_q   <= '0;
        rec_time_q    <= '0;
      end else begin
        prev_first_q  <= prev_first_d;
        prev_second_q <= prev_second_d;
        step_q        <= step_d;
        found_q       <= found_d;
        empty_q       <= empty_d;
        first_end_q   <= first_end_d;
        second_end_q  <= second_end_d;
        rec_kind_q    <= rec_kind_d;
        rec_cell_q    <= rec_cell_d;
        rec_prior_q   <= rec_prior_d;
        rec_time_q    <= rec_time_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_i |=> (step_q == '0) && !found_q && !empty_q)
    else $error("pair state not cleared after last timestep");

  a_found_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> !empty_q)
    else $error("conflict recorded for an empty pair");

  a_first_step_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == '0) |-> !found_q && !empty_q && !first_end_q && !second_end_q)
    else $error("state set before the first timestep");

  a_edge_has_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && (rec_kind_q == KIND_EDGE) |-> (rec_time_q != '0))
    else $error("edge conflict recorded at the first timestep");

endmodule : ppcd_core

`default_nettype wire

[src/ppcd_out_reg.sv]
// ----------------------------------------------------------------------------
// ppcd_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcd_out_reg #(
  parameter int unsigned DataBits = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire ppcd_pkg::ppcd_kind_e kind_i,
  input  wire logic [DataBits-1:0]  data_i,
  output logic                      free_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output ppcd_pkg::ppcd_kind_e      m_kind_o,
  output logic [DataBits-1:0]       m_data_o
);
  import ppcd_pkg::*;

  logic                valid_q, valid_d;
  ppcd_kind_e          kind_q;
  logic [DataBits-1:0] data_q;

  // Free when empty or when the held result is taken this cycle.
  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= kind_i;
      data_q <= data_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_kind_o  = kind_q;
  assign m_data_o  = data_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten while held");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !m_ready_i |=> valid_q && $stable(data_q))
    else $error("stalled result changed");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (kind_q == KIND_NONE) |-> (data_q[DataBits-1:16] == '0))
    else $error("result without conflict carries conflict fields");

endmodule : ppcd_out_reg

`default_nettype wire
